// File: src/pixel_line_buffer_quantized_core_assert.svh
// Assertion macros for the line buffer RTL.
`ifndef PIXEL_LINE_BUFFER_QUANTIZED_CORE_ASSERT_SVH
`define PIXEL_LINE_BUFFER_QUANTIZED_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PLBQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PLBQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/plbq_pkg.sv
package plbq_pkg;

    localparam int ACT_W      = 3;
    localparam int COMP_W     = 2;
    localparam int POS_W      = 15;
    localparam int DATA_W     = 16;
    localparam int NCOMP_W    = 3;
    localparam int LW_W       = 14;
    localparam int BITS_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam int BANKS      = 2;
    localparam int RESET_FILL = 128;

    localparam logic [ACT_W-1:0] ACT_READ_PREV  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_READ_CURR  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_WRITE_CURR = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READ_ORIG  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_WRITE_ORIG = 3'd4;
    localparam logic [ACT_W-1:0] ACT_SWAP       = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COMP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LEN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BITS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEBUF_BITS = 2'd3;

    typedef struct packed {
        logic [BITS_W-1:0] sample_bits;
        logic [BITS_W-1:0] linebuf_bits;
    } t_round_cfg;

endpackage

// File: src/pixel_line_buffer_quantized_core.sv
// Per-component line buffer: current, original and two previous-line banks.
// Input channel (i_in_valid / o_in_stall) carries one access word: action,
// component, signed position, bank and write value. Output channel
// (o_out_valid / i_out_stall) returns read_data for the three read actions.
// Writes may follow each other every cycle while o_in_stall is low. A read
// is captured in the memory read register on acceptance, then moved to the
// output register once it is free; input stall stays high until then.
// Swap walks one sample per cycle through the current-line memory read port
// and the rounding unit, over ncomp * (row length + PAD_TOTAL) samples.
// Reset starts a clearing pass over MAX_COMPONENTS * 2 * (MAX_LINE_WIDTH +
// PAD_TOTAL) addresses (65664 with defaults) that loads 128 into the current
// and previous lines and 0 into the original line; no word is taken
// meanwhile, config writes are. Config registers are reset to 3, 1920, 8, 8.
// A finished read waits in the output register while the receiver stalls;
// a further write or swap is still taken, a further read waits its turn.
`include "pixel_line_buffer_quantized_core_assert.svh"

module pixel_line_buffer_quantized_core
    import plbq_pkg::*;
#(
    parameter int MAX_COMPONENTS = 4,
    parameter int MAX_LINE_WIDTH = 8192,
    parameter int PAD_LEFT       = 8,
    parameter int PAD_TOTAL      = 16,
    parameter int SAMPLE_WIDTH   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [ACT_W-1:0]       i_action,
    input  logic [COMP_W-1:0]      i_component,
    input  logic signed [POS_W-1:0] i_position,
    input  logic                   i_bank,
    input  logic [DATA_W-1:0]      i_write_value,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [DATA_W-1:0]      o_read_data
);

    localparam int ROW_SLOTS  = MAX_LINE_WIDTH + PAD_TOTAL;
    localparam int CURR_DEPTH = MAX_COMPONENTS * ROW_SLOTS;
    localparam int PREV_DEPTH = BANKS * CURR_DEPTH;
    localparam int IDX_W      = $clog2(ROW_SLOTS);
    localparam int NW         = $clog2(ROW_SLOTS + 1);
    localparam int CAW        = $clog2(CURR_DEPTH);
    localparam int PAW        = $clog2(PREV_DEPTH);
    localparam int PW         = ((NW > POS_W) ? NW : POS_W) + 2;
    localparam int LWC_W      = LW_W + 1;

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_READ     = 3'd2;
    localparam logic [2:0] ST_SWAP     = 3'd3;
    localparam logic [2:0] ST_SWAP_END = 3'd4;

    logic [2:0]              r_state, n_state;
    logic [PAW-1:0]          r_clr, n_clr;
    logic [NCOMP_W-1:0]      r_num_comp;
    logic [LW_W-1:0]         r_row_len;
    logic [BITS_W-1:0]       r_sample_bits;
    logic [BITS_W-1:0]       r_linebuf_bits;
    logic                    r_out_valid, n_out_valid;
    logic [DATA_W-1:0]       r_out_data, n_out_data;
    logic [ACT_W-1:0]        r_rd_sel, n_rd_sel;
    logic                    r_rd_zero, n_rd_zero;
    logic [COMP_W-1:0]       r_sw_comp, n_sw_comp;
    logic [IDX_W-1:0]        r_sw_idx, n_sw_idx;
    logic                    r_sw_bank, n_sw_bank;
    logic                    r_sw_wr_valid, n_sw_wr_valid;
    logic [PAW-1:0]          r_sw_wr_addr, n_sw_wr_addr;

    logic [NCOMP_W-1:0]      ncomp;
    logic [LWC_W-1:0]        lwc;
    logic [NW-1:0]           n_slots;
    t_round_cfg              round_cfg;
    logic signed [PW-1:0]    idx_s;
    logic signed [PW-1:0]    n_s;
    logic                    in_range;
    logic                    comp_ok;
    logic [IDX_W-1:0]        cl;
    logic [CAW-1:0]          acc_curr_addr;
    logic [PAW-1:0]          acc_prev_addr;
    logic [CAW-1:0]          sw_curr_addr;
    logic [PAW-1:0]          sw_prev_addr;
    logic                    acc;
    logic                    is_read;
    logic                    clearing;
    logic                    clr_low;
    logic                    sw_busy;
    logic [SAMPLE_WIDTH-1:0] wval;
    logic [SAMPLE_WIDTH-1:0] fill;
    logic [SAMPLE_WIDTH-1:0] rounded;
    logic [SAMPLE_WIDTH-1:0] rd_mux;

    logic                    curr_we, orig_we, prev_we;
    logic [CAW-1:0]          curr_waddr, orig_waddr, curr_raddr;
    logic [PAW-1:0]          prev_waddr;
    logic [SAMPLE_WIDTH-1:0] curr_wdata, orig_wdata, prev_wdata;
    logic                    curr_re, orig_re, prev_re;
    logic [SAMPLE_WIDTH-1:0] curr_rdata, orig_rdata, prev_rdata;

    // Register clamps
    always_comb begin
        ncomp = (r_num_comp > NCOMP_W'(MAX_COMPONENTS)) ? NCOMP_W'(MAX_COMPONENTS)
                                                          : r_num_comp;
        if (r_row_len == '0) begin
            lwc = LWC_W'(1);
        end else if ({1'b0, r_row_len} > LWC_W'(MAX_LINE_WIDTH)) begin
            lwc = LWC_W'(MAX_LINE_WIDTH);
        end else begin
            lwc = {1'b0, r_row_len};
        end
        n_slots = NW'(lwc) + NW'(PAD_TOTAL);
        if (r_sample_bits == '0) begin
            round_cfg.sample_bits = BITS_W'(1);
        end else if (r_sample_bits > BITS_W'(SAMPLE_WIDTH)) begin
            round_cfg.sample_bits = BITS_W'(SAMPLE_WIDTH);
        end else begin
            round_cfg.sample_bits = r_sample_bits;
        end
        if (r_linebuf_bits == '0) begin
            round_cfg.linebuf_bits = BITS_W'(1);
        end else if (r_linebuf_bits > BITS_W'(SAMPLE_WIDTH)) begin
            round_cfg.linebuf_bits = BITS_W'(SAMPLE_WIDTH);
        end else begin
            round_cfg.linebuf_bits = r_linebuf_bits;
        end
    end

    // Access index and addresses
    always_comb begin
        idx_s    = PW'(i_position) + PW'(PAD_LEFT);
        n_s      = $signed(PW'(n_slots));
        in_range = (idx_s >= 0) && (idx_s < n_s);
        comp_ok  = NCOMP_W'(i_component) < NCOMP_W'(MAX_COMPONENTS);
        if (idx_s < 0) begin
            cl = '0;
        end else if (idx_s >= n_s) begin
            cl = IDX_W'(n_slots - NW'(1));
        end else begin
            cl = idx_s[IDX_W-1:0];
        end
        acc_curr_addr = CAW'(i_component) * CAW'(ROW_SLOTS) + CAW'(cl);
        acc_prev_addr = PAW'({i_component, i_bank}) * PAW'(ROW_SLOTS) + PAW'(cl);
        sw_curr_addr  = CAW'(r_sw_comp) * CAW'(ROW_SLOTS) + CAW'(r_sw_idx);
        sw_prev_addr  = PAW'({r_sw_comp, r_sw_bank}) * PAW'(ROW_SLOTS) + PAW'(r_sw_idx);
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign acc        = i_in_valid && (r_state == ST_IDLE);
    assign is_read    = i_action inside {ACT_READ_PREV, ACT_READ_CURR, ACT_READ_ORIG};
    assign clearing   = (r_state == ST_CLEAR);
    assign clr_low    = (r_clr < PAW'(CURR_DEPTH));
    assign sw_busy    = (r_state == ST_SWAP) || (r_state == ST_SWAP_END);
    assign wval       = i_write_value[SAMPLE_WIDTH-1:0];
    assign fill       = SAMPLE_WIDTH'(RESET_FILL);

    // Memory ports
    always_comb begin
        curr_we    = (clearing && clr_low) ||
                     (acc && i_action == ACT_WRITE_CURR && comp_ok && in_range);
        curr_waddr = clearing ? r_clr[CAW-1:0] : acc_curr_addr;
        curr_wdata = clearing ? fill : wval;
        curr_re    = (r_state == ST_SWAP) || (acc && i_action == ACT_READ_CURR);
        curr_raddr = (r_state == ST_SWAP) ? sw_curr_addr : acc_curr_addr;

        orig_we    = (clearing && clr_low) ||
                     (acc && i_action == ACT_WRITE_ORIG && comp_ok && in_range);
        orig_waddr = clearing ? r_clr[CAW-1:0] : acc_curr_addr;
        orig_wdata = clearing ? '0 : wval;
        orig_re    = acc && i_action == ACT_READ_ORIG;

        prev_we    = clearing || r_sw_wr_valid;
        prev_waddr = clearing ? r_clr : r_sw_wr_addr;
        prev_wdata = clearing ? fill : rounded;
        prev_re    = acc && i_action == ACT_READ_PREV;
    end

    plbq_ram #(
        .DEPTH (CURR_DEPTH),
        .WIDTH (SAMPLE_WIDTH)
    ) u_curr (
        .i_clk   (i_clk),
        .i_we    (curr_we),
        .i_waddr (curr_waddr),
        .i_wdata (curr_wdata),
        .i_re    (curr_re),
        .i_raddr (curr_raddr),
        .o_rdata (curr_rdata)
    );

    plbq_ram #(
        .DEPTH (CURR_DEPTH),
        .WIDTH (SAMPLE_WIDTH)
    ) u_orig (
        .i_clk   (i_clk),
        .i_we    (orig_we),
        .i_waddr (orig_waddr),
        .i_wdata (orig_wdata),
        .i_re    (orig_re),
        .i_raddr (acc_curr_addr),
        .o_rdata (orig_rdata)
    );

    plbq_ram #(
        .DEPTH (PREV_DEPTH),
        .WIDTH (SAMPLE_WIDTH)
    ) u_prev (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_re    (prev_re),
        .i_raddr (acc_prev_addr),
        .o_rdata (prev_rdata)
    );

    plbq_round #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_round (
        .i_cfg    (round_cfg),
        .i_sample (curr_rdata),
        .o_sample (rounded)
    );

    always_comb begin
        case (r_rd_sel)
            ACT_READ_PREV: rd_mux = prev_rdata;
            ACT_READ_CURR: rd_mux = curr_rdata;
            default:       rd_mux = orig_rdata;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_clr         = r_clr;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_data    = r_out_data;
        n_rd_sel      = r_rd_sel;
        n_rd_zero     = r_rd_zero;
        n_sw_comp     = r_sw_comp;
        n_sw_idx      = r_sw_idx;
        n_sw_bank     = r_sw_bank;
        n_sw_wr_valid = (r_state == ST_SWAP);
        n_sw_wr_addr  = sw_prev_addr;
        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + PAW'(1);
                if (r_clr == PAW'(PREV_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (acc) begin
                    if (is_read) begin
                        n_state   = ST_READ;
                        n_rd_sel  = i_action;
                        n_rd_zero = !comp_ok || (i_action == ACT_READ_ORIG && !in_range);
                    end else if (i_action == ACT_SWAP && ncomp != '0) begin
                        n_state   = ST_SWAP;
                        n_sw_comp = '0;
                        n_sw_idx  = '0;
                        n_sw_bank = i_bank;
                    end
                end
            end
            ST_READ: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_rd_zero ? '0 : DATA_W'(rd_mux);
                    n_state     = ST_IDLE;
                end
            end
            ST_SWAP: begin
                if (r_sw_idx == IDX_W'(n_slots - NW'(1))) begin
                    n_sw_idx = '0;
                    if (NCOMP_W'(r_sw_comp) == ncomp - NCOMP_W'(1)) begin
                        n_state = ST_SWAP_END;
                    end else begin
                        n_sw_comp = r_sw_comp + COMP_W'(1);
                    end
                end else begin
                    n_sw_idx = r_sw_idx + IDX_W'(1);
                end
            end
            ST_SWAP_END: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_clr          <= '0;
            r_out_valid    <= 1'b0;
            r_sw_wr_valid  <= 1'b0;
            r_sw_comp      <= '0;
            r_sw_idx       <= '0;
            r_num_comp     <= NCOMP_W'(3);
            r_row_len      <= LW_W'(1920);
            r_sample_bits  <= BITS_W'(8);
            r_linebuf_bits <= BITS_W'(8);
        end else begin
            r_state       <= n_state;
            r_clr         <= n_clr;
            r_out_valid   <= n_out_valid;
            r_sw_wr_valid <= n_sw_wr_valid;
            r_sw_comp     <= n_sw_comp;
            r_sw_idx      <= n_sw_idx;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NUM_COMP:     r_num_comp     <= i_cfg_data[NCOMP_W-1:0];
                    CFG_ROW_LEN:      r_row_len      <= i_cfg_data[LW_W-1:0];
                    CFG_SAMPLE_BITS:  r_sample_bits  <= i_cfg_data[BITS_W-1:0];
                    CFG_LINEBUF_BITS: r_linebuf_bits <= i_cfg_data[BITS_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data   <= n_out_data;
        r_rd_sel     <= n_rd_sel;
        r_rd_zero    <= n_rd_zero;
        r_sw_bank    <= n_sw_bank;
        r_sw_wr_addr <= n_sw_wr_addr;
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

    `PLBQ_ASSERT_IMP(a_sw_wr_in_swap, r_sw_wr_valid, sw_busy, "swap write outside swap")
    `PLBQ_ASSERT_IMP(a_out_from_read, $rose(o_out_valid), $past(r_state) == ST_READ, "stray word")
    `PLBQ_ASSERT_NXT(a_swap_drains, r_state == ST_SWAP_END, !o_in_stall && !r_sw_wr_valid, "swap end")
    `PLBQ_ASSERT_IMP(a_sw_idx_range, r_state == ST_SWAP, NW'(r_sw_idx) < n_slots, "swap index")

endmodule

// File: src/plbq_ram.sv
module plbq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/plbq_round.sv
module plbq_round
    import plbq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  t_round_cfg              i_cfg,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    output logic [SAMPLE_WIDTH-1:0] o_sample
);

    localparam int SW1 = SAMPLE_WIDTH + 1;

    logic [BITS_W-1:0] sh;
    logic [SW1-1:0]    half;
    logic [SW1-1:0]    sum;
    logic [SW1-1:0]    q;
    logic [SW1-1:0]    top;
    logic [SW1-1:0]    res;

    always_comb begin
        sh   = i_cfg.sample_bits - i_cfg.linebuf_bits;
        half = SW1'(1) << (sh - BITS_W'(1));
        sum  = {1'b0, i_sample} + half;
        q    = (sum >> sh) << sh;
        top  = (SW1'(1) << i_cfg.sample_bits) - SW1'(1);
        res  = (q > top) ? top : q;
        if (i_cfg.sample_bits > i_cfg.linebuf_bits) begin
            o_sample = res[SAMPLE_WIDTH-1:0];
        end else begin
            o_sample = i_sample;
        end
    end

endmodule
